// ----- rtl/pip_pkg.sv -----
// Package for the point-in-polygon crossing-number core.
// Shared types and fixed constants; no dependencies.
package pip_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int IDX_WIDTH    = 6;
    localparam int COUNT_WIDTH  = 7;
    localparam int MIN_VERTICES = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    typedef struct packed {
        logic                          op;
        logic [IDX_WIDTH-1:0]          vertex_index;
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } t_cmd;

    typedef struct packed {
        logic                   inside_res;
        logic                   too_few_vertices;
        logic [COUNT_WIDTH-1:0] crossing_count;
    } t_res;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_vertex;

    // Marks an edge travelling through the test pipeline.
    typedef struct packed {
        logic vld;
        logic last;
    } t_edge_tag;

endpackage

// ----- rtl/pip_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ----- rtl/pip_edge.sv -----
// Two-stage exact edge-crossing test: span check and cross products, then compare.
// Depends on pip_pkg.
module pip_edge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pip_pkg::t_edge_tag                     i_tag,
    input  pip_pkg::t_vertex                       i_v,
    input  pip_pkg::t_vertex                       i_w,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_px,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_py,
    output pip_pkg::t_edge_tag                     o_tag,
    output logic                                   o_hit
);

    localparam int DW = pip_pkg::COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dx, dy, ax, by;
    logic signed [PW-1:0] n_pa, n_pb;
    logic                 n_span;

    logic signed [PW-1:0] r_pa, r_pb;
    logic                 r_span, r_dy_pos;
    pip_pkg::t_edge_tag   r_tag;

    always_comb begin
        dx     = {i_w.x[DW-2], i_w.x} - {i_v.x[DW-2], i_v.x};
        dy     = {i_w.y[DW-2], i_w.y} - {i_v.y[DW-2], i_v.y};
        ax     = {i_px[DW-2], i_px}   - {i_v.x[DW-2], i_v.x};
        by     = {i_py[DW-2], i_py}   - {i_v.y[DW-2], i_v.y};
        n_pa   = ax * dy;
        n_pb   = dx * by;
        // half-open span: lower end in, upper end out
        n_span = ((i_v.y <= i_py) && (i_py < i_w.y)) ||
                 ((i_w.y <= i_py) && (i_py < i_v.y));
    end

    always_ff @(posedge i_clk) begin
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_span   <= n_span;
        r_dy_pos <= (i_w.y > i_v.y);
        o_hit    <= r_span && (r_dy_pos ? (r_pa < r_pb) : (r_pb < r_pa));
        if (!i_rst_n) begin
            r_tag <= '0;
            o_tag <= '0;
        end else begin
            r_tag <= i_tag;
            o_tag <= r_tag;
        end
    end

endmodule

// ----- rtl/point_in_polygon_test_core.sv -----
// Point-in-polygon crossing-number core: vertex table in RAM, edge walk per query.
// Depends on pip_pkg, pip_ram and pip_edge.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------
//  command   | start / busy         | i_cmd  (pip_pkg::t_cmd)
//  result    | o_res_valid (strobe) | o_res  (pip_pkg::t_res)
//  config    | i_cfg_we             | i_cfg_data (vertex_count)
//
// A vertex write leaves busy low. A query with N vertices in use (N >= 3)
// holds busy while the RAM read port fetches the closing vertex and then one
// vertex per cycle, and while the closing edge clears the read register and
// the test pipeline. The result strobes as busy drops. With fewer than three
// vertices the result strobes on the next cycle. Reset clears control state
// only; the vertex table is undefined until written. The receiver cannot
// stall results.
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  pip_pkg::t_cmd                       i_cmd,
    output logic                                busy,
    output logic                                o_res_valid,
    output pip_pkg::t_res                       o_res,
    input  logic                                i_cfg_we,
    input  logic [pip_pkg::COUNT_WIDTH-1:0]     i_cfg_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = pip_pkg::COUNT_WIDTH;
    localparam int VW = 2 * pip_pkg::COORD_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state                               r_state;
    logic [CW-1:0]                        r_vcount;
    logic [CW-1:0]                        n_s;
    logic [AW-1:0]                        r_addr;
    logic [CW:0]                          r_left;
    logic                                 r_first;
    logic                                 r_rd_vld, r_rd_first, r_rd_last;
    pip_pkg::t_vertex                     r_prev;
    logic signed [pip_pkg::COORD_WIDTH-1:0] r_px, r_py;
    logic [CW-1:0]                        r_count;
    logic [CW-1:0]                        n_count;

    logic                                 accept, wr_en, rd_en;
    logic [VW-1:0]                        rd_data;
    pip_pkg::t_vertex                     rd_vertex;
    pip_pkg::t_edge_tag                   e_in_tag, e_out_tag;
    logic                                 e_hit;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign wr_en     = accept && (i_cmd.op == pip_pkg::OP_WRITE) &&
                       (32'(i_cmd.vertex_index) < MAX_VERTICES);
    assign rd_en     = (r_state == S_RUN);
    assign rd_vertex = pip_pkg::t_vertex'(rd_data);
    assign n_s       = (32'(r_vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : r_vcount;
    assign n_count   = r_count + CW'(e_hit);

    assign e_in_tag.vld  = r_rd_vld && !r_rd_first;
    assign e_in_tag.last = r_rd_last;

    pip_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_vtab (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_cmd.vertex_index)),
        .i_wdata ({i_cmd.vertex_x, i_cmd.vertex_y}),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (e_in_tag),
        .i_v     (rd_vertex),
        .i_w     (r_prev),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_tag   (e_out_tag),
        .o_hit   (e_hit)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= i_cmd.point_x;
            r_py <= i_cmd.point_y;
        end
        if (r_rd_vld) begin
            r_prev <= rd_vertex;
        end
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_data;
        end
    end

    // read issue: closing vertex first, then entries from zero upward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            r_rd_vld   <= rd_en;
            r_rd_first <= rd_en && r_first;
            r_rd_last  <= rd_en && (r_left == (CW + 1)'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b0;
            r_left      <= '0;
            r_addr      <= '0;
            r_count     <= '0;
            o_res_valid <= 1'b0;
            o_res       <= '0;
        end else begin
            o_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_cmd.op == pip_pkg::OP_TEST)) begin
                        if (n_s < CW'(pip_pkg::MIN_VERTICES)) begin
                            o_res_valid            <= 1'b1;
                            o_res.inside_res       <= 1'b0;
                            o_res.too_few_vertices <= 1'b1;
                            o_res.crossing_count   <= '0;
                        end else begin
                            r_state <= S_RUN;
                            r_first <= 1'b1;
                            r_left  <= {1'b0, n_s} + (CW + 1)'(1);
                            r_addr  <= AW'(n_s - CW'(1));
                            r_count <= '0;
                        end
                    end
                end
                S_RUN: begin
                    r_first <= 1'b0;
                    r_addr  <= r_first ? '0 : r_addr + AW'(1);
                    r_left  <= r_left - (CW + 1)'(1);
                    if (r_left == (CW + 1)'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // hold until the closing edge leaves the test pipeline
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (e_out_tag.vld) begin
                if (e_out_tag.last) begin
                    r_state                <= S_IDLE;
                    r_count                <= '0;
                    o_res_valid            <= 1'b1;
                    o_res.inside_res       <= n_count[0];
                    o_res.too_few_vertices <= 1'b0;
                    o_res.crossing_count   <= n_count;
                end else begin
                    r_count <= n_count;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_result_while_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !o_res_valid)
        else $error("result strobed while edges are still being read");

    a_last_edge_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_out_tag.vld && e_out_tag.last) |-> (r_state == S_DRAIN))
        else $error("closing edge left the pipeline outside the drain state");

    a_too_few_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.too_few_vertices) |->
            (!o_res.inside_res && (o_res.crossing_count == '0)))
        else $error("short polygon result carries a crossing count");

    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.too_few_vertices) |->
            (o_res.inside_res == o_res.crossing_count[0]))
        else $error("inside flag disagrees with crossing parity");

    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.op == pip_pkg::OP_TEST)) |=> (busy || o_res_valid))
        else $error("query transaction neither started a walk nor answered");
`endif

endmodule
